// ===== hdl/sdr_pkg.sv =====
package sdr_pkg;

    localparam int DATA_WIDTH = 32;
    // input register, one register per quotient bit, output register
    localparam int LATENCY = DATA_WIDTH + 2;

    typedef logic [DATA_WIDTH-1:0] word_t;

    typedef struct packed {
        logic  valid;
        logic  neg_q;
        logic  neg_r;
        logic  dbz;
        word_t rem;
        word_t quo;
        word_t dvsr;
    } sdr_stage_t;

    function automatic word_t sdr_magnitude(input word_t v);
        word_t m;
        m = v[DATA_WIDTH-1] ? (~v + word_t'(1)) : v;
        return m;
    endfunction

    function automatic word_t sdr_negate_if(input word_t v, input logic neg);
        word_t m;
        m = neg ? (~v + word_t'(1)) : v;
        return m;
    endfunction

endpackage

// ===== hdl/sdr_stage.sv =====
module sdr_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  sdr_pkg::sdr_stage_t in_item,
    output sdr_pkg::sdr_stage_t out_item
);
    import sdr_pkg::*;

    logic [DATA_WIDTH:0] trial;
    logic [DATA_WIDTH:0] diff;
    sdr_stage_t          item_next;
    sdr_stage_t          item_reg;

    // shift the next dividend bit into the partial remainder, try a subtract
    always_comb
    begin
        trial     = {in_item.rem, in_item.quo[DATA_WIDTH-1]};
        diff      = trial - {1'b0, in_item.dvsr};
        item_next = in_item;
        if (!diff[DATA_WIDTH])
        begin
            item_next.rem = diff[DATA_WIDTH-1:0];
            item_next.quo = {in_item.quo[DATA_WIDTH-2:0], 1'b1};
        end
        else
        begin
            item_next.rem = trial[DATA_WIDTH-1:0];
            item_next.quo = {in_item.quo[DATA_WIDTH-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_reg <= '0;
        end
        else
        begin
            item_reg <= item_next;
        end
    end

    assign out_item = item_reg;

endmodule

// ===== hdl/signed_divide_remainder.sv =====
// Channel  | Ports                                          | Handshake
// ---------+------------------------------------------------+---------------------------
// in       | dividend[31:0], divisor[31:0]                  | start && !busy
// out      | quotient[31:0], remainder[31:0], divide_by_zero | done, one cycle, no stall
//
// Fully pipelined restoring divider: one quotient bit per stage.
// An item can enter every cycle. Each item passes the input register (magnitudes),
// 32 subtract stages and the output register (sign fixup), in that order.
// busy stays low: the pipeline never holds.
// rst_n clears the pipeline stages and done; the output data registers are not reset.
module signed_divide_remainder (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [sdr_pkg::DATA_WIDTH-1:0] dividend,
    input  logic signed [sdr_pkg::DATA_WIDTH-1:0] divisor,
    output logic                               done,
    output logic signed [sdr_pkg::DATA_WIDTH-1:0] quotient,
    output logic signed [sdr_pkg::DATA_WIDTH-1:0] remainder,
    output logic                               divide_by_zero
);
    import sdr_pkg::*;

    sdr_stage_t stage [0:DATA_WIDTH];
    sdr_stage_t entry_next;
    sdr_stage_t entry_reg;
    word_t      quotient_next;
    word_t      remainder_next;
    word_t      quotient_reg;
    word_t      remainder_reg;
    logic       dbz_reg;
    logic       done_reg;
    logic       accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        entry_next.valid = accept;
        entry_next.neg_q = dividend[DATA_WIDTH-1] ^ divisor[DATA_WIDTH-1];
        entry_next.neg_r = dividend[DATA_WIDTH-1];
        entry_next.dbz   = (divisor == '0);
        entry_next.rem   = '0;
        entry_next.quo   = sdr_magnitude(word_t'(dividend));
        entry_next.dvsr  = sdr_magnitude(word_t'(divisor));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign stage[0] = entry_reg;

    for (genvar i = 0; i < DATA_WIDTH; i++)
    begin : g_stage
        sdr_stage u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_item  (stage[i]),
            .out_item (stage[i+1])
        );
    end

    // divide by zero: the subtract chain leaves the dividend magnitude as the
    // remainder, so only the quotient needs overriding
    always_comb
    begin
        remainder_next = sdr_negate_if(stage[DATA_WIDTH].rem, stage[DATA_WIDTH].neg_r);
        if (stage[DATA_WIDTH].dbz)
        begin
            quotient_next = '1;
        end
        else
        begin
            quotient_next = sdr_negate_if(stage[DATA_WIDTH].quo, stage[DATA_WIDTH].neg_q);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= stage[DATA_WIDTH].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        quotient_reg  <= quotient_next;
        remainder_reg <= remainder_next;
        dbz_reg       <= stage[DATA_WIDTH].dbz;
    end

    assign done           = done_reg;
    assign quotient       = quotient_reg;
    assign remainder      = remainder_reg;
    assign divide_by_zero = dbz_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##(LATENCY) done)
        else $error("item did not complete after pipeline latency");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result without a matching item");

    a_dbz_quotient: assert property (@(posedge clk) disable iff (!rst_n)
        done && divide_by_zero |-> quotient == '1)
        else $error("divide by zero quotient not all ones");

    a_dbz_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        done && divide_by_zero |-> remainder == $past(dividend, LATENCY))
        else $error("divide by zero remainder differs from dividend");

    a_rem_sign: assert property (@(posedge clk) disable iff (!rst_n)
        done && !divide_by_zero && remainder != '0
            |-> remainder[DATA_WIDTH-1] == $past(dividend[DATA_WIDTH-1], LATENCY))
        else $error("remainder sign differs from dividend sign");

endmodule
